// ----- hdl/mf3_pkg.sv -----
// Shared constants and types for the 3x3 median filter.
package mf3_pkg;

    // Line store sizing: interior width plus the two border columns.
    localparam int MAX_WIDTH    = 512;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int STORE_DEPTH  = MAX_WIDTH + 2;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // Field and counter widths.
    localparam int PIX_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 13;
    localparam int WIN_N = 9;

    // Queue between the window front end and the sorting back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pix;

    // Nine window pixels: index 0..5 are the two older columns, top to bottom,
    // then the newest column (top, middle, current pixel).
    typedef t_pix [WIN_N-1:0] t_win;

    typedef struct packed {
        t_win v;
        logic last;
    } t_item;

    // Effective frame size and the restart strobe from a register write.
    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic             restart;
    } t_cfg;

endpackage

// ----- hdl/median_filter_3x3_core.sv -----
// Top level of the 3x3 median filter: configuration registers and block wiring.
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  pixel     in         i_valid / o_ready    i_pixel_in
//  median    out        o_valid / i_ready    o_median_out, o_frame_last
//  config    in         psel/penable/pready  paddr, pwrite, pwdata -> prdata
//
// One pixel transaction is accepted per cycle when the output side keeps up.
// A median leaves after the transaction of its bottom-right pixel: the line stores
// are read when that pixel is accepted, the window then enters the queue, and three
// sorter stages follow.
// Reset is synchronous and clears all control state; the line stores are not cleared.
// When the output stalls, the sorter holds and the four-entry queue fills; the
// pixel input stalls only once the queue has no room for the window in flight.
module median_filter_3x3_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Pixel input.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_pixel_in,
    // Median output.
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_median_out,
    output logic                o_frame_last,
    // Register port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Register index is the word address; byte offsets within a word are ignored.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [mf3_pkg::COL_W-1:0]   r_frame_width;
    logic [mf3_pkg::ROW_W-1:0]   r_frame_height;

    logic                        cfg_wr;
    mf3_pkg::t_cfg               cfg;
    logic                        push;
    mf3_pkg::t_item              push_item;
    logic                        pop;
    mf3_pkg::t_item              q_item;
    logic [mf3_pkg::Q_CW-1:0]    q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::COL_W'(mf3_pkg::MAX_WIDTH);
            r_frame_height <= mf3_pkg::ROW_W'(512);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  r_frame_width  <= pwdata[mf3_pkg::COL_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[mf3_pkg::ROW_W-1:0];
                default:    r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_frame_width);
            REG_HEIGHT: prdata = 32'(r_frame_height);
            default:    prdata = '0;
        endcase
    end

    // Out-of-range sizes are clamped: zero acts as one, and anything above the
    // maximum width or the height limit acts as that limit.
    always_comb begin
        if (r_frame_width == '0) begin
            cfg.width = mf3_pkg::COL_W'(1);
        end else if (r_frame_width > mf3_pkg::COL_W'(mf3_pkg::MAX_WIDTH)) begin
            cfg.width = mf3_pkg::COL_W'(mf3_pkg::MAX_WIDTH);
        end else begin
            cfg.width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            cfg.height = mf3_pkg::ROW_W'(1);
        end else if (r_frame_height > mf3_pkg::ROW_W'(mf3_pkg::HEIGHT_LIMIT)) begin
            cfg.height = mf3_pkg::ROW_W'(mf3_pkg::HEIGHT_LIMIT);
        end else begin
            cfg.height = r_frame_height;
        end
        // Any register write restarts the frame position.
        cfg.restart = cfg_wr;
    end

    mf3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_in (i_pixel_in),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_item     (push_item)
    );

    mf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_count (q_count)
    );

    mf3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_count != '0),
        .i_q_item     (q_item),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_median_out (o_median_out),
        .o_frame_last (o_frame_last)
    );

endmodule

// ----- hdl/mf3_front.sv -----
// Front end: accepts pixels, tracks the frame position, holds line stores and window.
module mf3_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mf3_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  mf3_pkg::t_pix          i_pixel_in,
    input  logic [mf3_pkg::Q_CW-1:0] i_q_count,
    output logic                   o_push,
    output mf3_pkg::t_item         o_item
);

    typedef struct packed {
        mf3_pkg::t_pix up;
        mf3_pkg::t_pix mid;
    } t_line;

    t_line                         r_mem [mf3_pkg::STORE_DEPTH];
    t_line                         r_rd;
    mf3_pkg::t_pix                 r_win [6];
    logic [mf3_pkg::COL_W-1:0]     r_col;
    logic [mf3_pkg::ROW_W-1:0]     r_row;
    logic                          r_b_valid;
    logic                          r_b_res;
    logic                          r_b_last;
    mf3_pkg::t_pix                 r_b_pix;
    logic [mf3_pkg::ADDR_W-1:0]    r_b_addr;

    logic                          accept;
    logic                          col_end;
    logic                          row_end;
    logic [mf3_pkg::Q_CW:0]        n_fill;

    // Count the item in the window stage as if it will occupy a queue slot.
    assign n_fill  = (mf3_pkg::Q_CW+1)'(i_q_count) + (mf3_pkg::Q_CW+1)'(r_b_valid);
    assign o_ready = n_fill < (mf3_pkg::Q_CW+1)'(mf3_pkg::Q_DEPTH);
    assign accept  = i_valid && o_ready;

    assign col_end = (mf3_pkg::COL_W+1)'(r_col) >= (mf3_pkg::COL_W+1)'(i_cfg.width) + 1'b1;
    assign row_end = (mf3_pkg::ROW_W+1)'(r_row) >= (mf3_pkg::ROW_W+1)'(i_cfg.height) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
            if (i_cfg.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Capture the pixel and its position class; read both line stores.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix  <= i_pixel_in;
            r_b_addr <= r_col[mf3_pkg::ADDR_W-1:0];
            r_b_res  <= (r_row >= mf3_pkg::ROW_W'(2)) && (r_col >= mf3_pkg::COL_W'(2));
            r_b_last <= row_end && col_end;
            r_rd     <= r_mem[r_col[mf3_pkg::ADDR_W-1:0]];
        end
    end

    // The old middle line moves up and the new pixel becomes the middle line.
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_mem[r_b_addr] <= '{up: r_rd.mid, mid: r_b_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_b_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_rd.up;
            r_win[4] <= r_rd.mid;
            r_win[5] <= r_b_pix;
        end
    end

    assign o_push      = r_b_valid && r_b_res;
    assign o_item.v    = {r_b_pix, r_rd.mid, r_rd.up,
                          r_win[5], r_win[4], r_win[3], r_win[2], r_win[1], r_win[0]};
    assign o_item.last = r_b_last;

endmodule

// ----- hdl/mf3_fifo.sv -----
// Short queue of complete windows between the front end and the sorter.
module mf3_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  mf3_pkg::t_item           i_item,
    input  logic                     i_pop,
    output mf3_pkg::t_item           o_item,
    output logic [mf3_pkg::Q_CW-1:0] o_count
);

    mf3_pkg::t_item               r_mem [mf3_pkg::Q_DEPTH];
    logic [mf3_pkg::Q_AW-1:0]     r_wr;
    logic [mf3_pkg::Q_AW-1:0]     r_rd;
    logic [mf3_pkg::Q_CW-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ----- hdl/mf3_back.sv -----
// Back end: three-stage median-of-nine exchange network with the output register.
module mf3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mf3_pkg::t_item i_q_item,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output mf3_pkg::t_pix  o_median_out,
    output logic           o_frame_last
);

    function automatic mf3_pkg::t_pix pix_min(mf3_pkg::t_pix a, mf3_pkg::t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::t_pix pix_max(mf3_pkg::t_pix a, mf3_pkg::t_pix b);
        return (a < b) ? b : a;
    endfunction

    // Compare-exchange: smaller value to position i, larger to position j.
    function automatic mf3_pkg::t_win cas(mf3_pkg::t_win v, logic [3:0] i, logic [3:0] j);
        mf3_pkg::t_win r;
        r    = v;
        r[i] = pix_min(v[i], v[j]);
        r[j] = pix_max(v[i], v[j]);
        return r;
    endfunction

    logic           adv;
    mf3_pkg::t_win  s1_n;
    mf3_pkg::t_win  s2_n;
    mf3_pkg::t_pix  m_a;
    mf3_pkg::t_pix  m_b;
    mf3_pkg::t_pix  m_c;

    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    mf3_pkg::t_win  r_s1;
    logic           r_l1;
    mf3_pkg::t_pix  r_p2;
    mf3_pkg::t_pix  r_p4;
    mf3_pkg::t_pix  r_p6;
    logic           r_l2;
    mf3_pkg::t_pix  r_median;
    logic           r_last;

    assign adv   = !r_v3 || i_ready;
    assign o_pop = adv && i_q_valid;

    // Sort each column of three.
    always_comb begin
        s1_n = i_q_item.v;
        s1_n = cas(s1_n, 4'd1, 4'd2);
        s1_n = cas(s1_n, 4'd4, 4'd5);
        s1_n = cas(s1_n, 4'd7, 4'd8);
        s1_n = cas(s1_n, 4'd0, 4'd1);
        s1_n = cas(s1_n, 4'd3, 4'd4);
        s1_n = cas(s1_n, 4'd6, 4'd7);
        s1_n = cas(s1_n, 4'd1, 4'd2);
        s1_n = cas(s1_n, 4'd4, 4'd5);
        s1_n = cas(s1_n, 4'd7, 4'd8);
    end

    // Cross the columns; only positions 2, 4 and 6 can still hold the median.
    always_comb begin
        s2_n = r_s1;
        s2_n = cas(s2_n, 4'd0, 4'd3);
        s2_n = cas(s2_n, 4'd5, 4'd8);
        s2_n = cas(s2_n, 4'd4, 4'd7);
        s2_n = cas(s2_n, 4'd3, 4'd6);
        s2_n = cas(s2_n, 4'd1, 4'd4);
        s2_n = cas(s2_n, 4'd2, 4'd5);
        s2_n = cas(s2_n, 4'd4, 4'd7);
    end

    // Median of the three survivors.
    always_comb begin
        m_a = pix_min(r_p4, r_p2);
        m_b = pix_max(r_p4, r_p2);
        m_c = pix_max(r_p6, m_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1     <= s1_n;
            r_l1     <= i_q_item.last;
            r_p2     <= s2_n[2];
            r_p4     <= s2_n[4];
            r_p6     <= s2_n[6];
            r_l2     <= r_l1;
            r_median <= pix_min(m_c, m_b);
            r_last   <= r_l2;
        end
    end

    assign o_valid      = r_v3;
    assign o_median_out = r_median;
    assign o_frame_last = r_last;

endmodule

// ----- hdl/mf3_checker.sv -----
// Port-level checks for the 3x3 median filter and their binding to the top level.
module mf3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_pixel_in,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_median_out,
    input logic        o_frame_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_median_out) && $stable(o_frame_last))
        else $error("median output changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

    // The register port never inserts wait states.
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port stalled");

    // A width write reads back on the next cycle.
    a_width_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> !(psel && !pwrite && !paddr[2]) || prdata[9:0] == $past(pwdata[9:0]))
        else $error("frame width read back mismatch");

    // A height write reads back on the next cycle.
    a_height_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2]
        |=> !(psel && !pwrite && paddr[2]) || prdata[12:0] == $past(pwdata[12:0]))
        else $error("frame height read back mismatch");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (.*);
